[hw/rtl/ogmi_pkg.sv]
// Package for the occupancy grid mark-and-inflate unit.
// Holds operation codes, command enum, status struct. No dependencies.
package ogmi_pkg;
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_POINT   = 2'd1;
    localparam logic [1:0] OP_INFLATE = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    localparam logic [7:0] MARK_VALUE = 8'sd100;
    localparam logic [15:0] FAR_DIST  = 16'hFFFF;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_PT_MUL,
        CMD_PT_MARK,
        CMD_RD_ADDR,
        CMD_RD_TAKE,
        CMD_FW_START,
        CMD_FW_STEP,
        CMD_BW_START,
        CMD_BW_STEP,
        CMD_CLR_STEP
    } t_cmd;

    typedef struct packed {
        logic fw_done;
        logic bw_done;
        logic clr_done;
    } t_status;
endpackage

[hw/rtl/ogmi_ctrl.sv]
// Controller state machine of the mark-and-inflate unit.
// Depends on ogmi_pkg; drives commands to ogmi_datapath.
module ogmi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_operation,
    input  logic              i_out_free,
    input  ogmi_pkg::t_status i_status,
    output logic              o_ready,
    output ogmi_pkg::t_cmd    o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_PT1, S_PT2, S_RD1, S_RD2, S_FW0, S_FW, S_BW0, S_BW, S_CLR
    } t_state;

    t_state r_state, n_state;

    // Next state and command selection.
    always_comb begin
        n_state = r_state;
        o_cmd   = ogmi_pkg::CMD_NONE;
        o_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_operation)
                        ogmi_pkg::OP_LOAD:  o_cmd = ogmi_pkg::CMD_LOAD;
                        ogmi_pkg::OP_POINT: begin
                            o_cmd = ogmi_pkg::CMD_PT_MUL;
                            n_state = S_PT1;
                        end
                        ogmi_pkg::OP_INFLATE: n_state = S_FW0;
                        default: begin
                            o_cmd = ogmi_pkg::CMD_RD_ADDR;
                            n_state = S_RD1;
                        end
                    endcase
                end
            end
            S_PT1: n_state = S_PT2;
            S_PT2: begin
                o_cmd = ogmi_pkg::CMD_PT_MARK;
                n_state = S_IDLE;
            end
            S_RD1: n_state = S_RD2;
            S_RD2: begin
                if (i_out_free) begin
                    o_cmd = ogmi_pkg::CMD_RD_TAKE;
                    n_state = S_IDLE;
                end
            end
            S_FW0: begin
                o_cmd = ogmi_pkg::CMD_FW_START;
                n_state = S_FW;
            end
            S_FW: begin
                o_cmd = ogmi_pkg::CMD_FW_STEP;
                if (i_status.fw_done) n_state = S_BW0;
            end
            S_BW0: begin
                o_cmd = ogmi_pkg::CMD_BW_START;
                n_state = S_BW;
            end
            S_BW: begin
                o_cmd = ogmi_pkg::CMD_BW_STEP;
                if (i_status.bw_done) n_state = S_CLR;
            end
            S_CLR: begin
                o_cmd = ogmi_pkg::CMD_CLR_STEP;
                if (i_status.clr_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

[hw/rtl/ogmi_datapath.sv]
// Datapath of the mark-and-inflate unit: grids, pointers, quantizer, sweeps.
// Depends on ogmi_pkg; driven by ogmi_ctrl.
module ogmi_datapath #(
    parameter int MAX_SIDE = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ogmi_pkg::t_cmd       i_cmd,
    input  logic [7:0]           i_cell_value,
    input  logic [31:0]          i_point_x,
    input  logic [31:0]          i_point_y,
    input  logic [7:0]           i_grid_width,
    input  logic [7:0]           i_grid_height,
    input  logic [31:0]          i_origin_x,
    input  logic [31:0]          i_origin_y,
    input  logic [31:0]          i_inv_resolution,
    input  logic [30:0]          i_half_extent_x,
    input  logic [30:0]          i_half_extent_y,
    input  logic [7:0]           i_radius_cells,
    output ogmi_pkg::t_status    o_status,
    output logic [7:0]           o_rd_data,
    output logic                 o_rd_last
);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int IW    = (SW > 8) ? SW : 8;

    // Effective grid sides.
    logic [IW-1:0] w_raw, h_raw;
    logic [SW-1:0] w_eff, h_eff;
    logic [CW-1:0] size;
    assign w_raw = IW'(i_grid_width);
    assign h_raw = IW'(i_grid_height);
    assign w_eff = (w_raw == '0) ? SW'(1) :
                   (w_raw > IW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(w_raw);
    assign h_eff = (h_raw == '0) ? SW'(1) :
                   (h_raw > IW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(h_raw);
    assign size  = CW'(w_eff * h_eff);

    // Memories.
    logic [7:0]  base_mem [CELLS];
    logic        mark_mem [CELLS];
    logic [15:0] dist_mem [CELLS];

    // Pointers.
    logic [CW-1:0] r_load_ptr, r_read_ptr, r_rd_idx;
    logic [CW-1:0] ld_cur, rd_cur;
    assign ld_cur = (r_load_ptr >= size) ? '0 : r_load_ptr;
    assign rd_cur = (r_read_ptr >= size) ? '0 : r_read_ptr;

    // Quantizer stage one: differences and bound checks.
    logic [32:0] dx, dy;
    logic [32:0] r_mag_x, r_mag_y;
    logic        r_neg_x, r_neg_y, r_in_bound;
    logic [65:0] r_prod_x, r_prod_y;
    logic        r2_neg_x, r2_neg_y, r2_in_bound;
    assign dx = {i_point_x[31], i_point_x} - {i_origin_x[31], i_origin_x};
    assign dy = {i_point_y[31], i_point_y} - {i_origin_y[31], i_origin_y};

    logic signed [32:0] px, py, hx, hy;
    assign px = $signed({i_point_x[31], i_point_x});
    assign py = $signed({i_point_y[31], i_point_y});
    assign hx = $signed({2'b00, i_half_extent_x});
    assign hy = $signed({2'b00, i_half_extent_y});

    // Quantizer final index decode.
    logic [33:0] idx_x, idx_y;
    logic        ok_x, ok_y;
    always_comb begin
        idx_x = (r_prod_x[65:32] + 34'(r_prod_x[31]));
        idx_y = (r_prod_y[65:32] + 34'(r_prod_y[31]));
        ok_x = r2_neg_x ? (r_prod_x <= 66'h80000000) : (idx_x < 34'(w_eff));
        ok_y = r2_neg_y ? (r_prod_y <= 66'h80000000) : (idx_y < 34'(h_eff));
        if (r2_neg_x) idx_x = '0;
        if (r2_neg_y) idx_y = '0;
    end
    logic [AW-1:0] mark_addr;
    assign mark_addr = AW'(idx_y[SW-1:0] * w_eff + idx_x[SW-1:0]);

    // Sweep counters: row and column, plus linear index.
    logic [SW-1:0] r_row, r_col;
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_clr;
    logic [15:0]   r_d_left;
    logic [15:0]   up_d, here_d;
    logic          here_m;
    logic [AW-1:0] nb_idx;

    // Sweep steps in three phases: issue reads, wait, then combine and write.
    typedef enum logic [1:0] { P_RD, P_WAIT, P_WR } t_ph;
    t_ph r_ph;

    function automatic logic [15:0] dinc(input logic [15:0] a);
        dinc = (a == ogmi_pkg::FAR_DIST) ? a : a + 16'd1;
    endfunction
    function automatic logic [15:0] dmin(input logic [15:0] a, input logic [15:0] b);
        dmin = (a < b) ? a : b;
    endfunction

    logic fw_last, bw_last;
    assign fw_last = (r_row == h_eff - SW'(1)) && (r_col == w_eff - SW'(1));
    assign bw_last = (r_row == '0) && (r_col == '0);

    logic [15:0] new_fw, new_bw;
    always_comb begin
        new_fw = here_m ? 16'd0 : ogmi_pkg::FAR_DIST;
        if (r_row != '0) new_fw = dmin(new_fw, dinc(up_d));
        if (r_col != '0) new_fw = dmin(new_fw, dinc(r_d_left));
        new_bw = here_d;
        if (r_row != h_eff - SW'(1)) new_bw = dmin(new_bw, dinc(up_d));
        if (r_col != w_eff - SW'(1)) new_bw = dmin(new_bw, dinc(r_d_left));
    end

    assign nb_idx = (i_cmd == ogmi_pkg::CMD_FW_STEP) ? AW'(r_idx - AW'(w_eff))
                                                     : AW'(r_idx + AW'(w_eff));

    // The controller watches each flag only in the state of its own sweep.
    assign o_status.fw_done  = (r_ph == P_WR) && fw_last;
    assign o_status.bw_done  = (r_ph == P_WR) && bw_last;
    assign o_status.clr_done = (r_clr == CW'(CELLS - 1));

    // Memory ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd == ogmi_pkg::CMD_LOAD) base_mem[AW'(ld_cur)] <= i_cell_value;
        if (i_cmd == ogmi_pkg::CMD_RD_ADDR) o_rd_data <= base_mem[AW'(rd_cur)];
        if (i_cmd == ogmi_pkg::CMD_BW_STEP && r_ph == P_WR &&
            new_bw <= 16'(i_radius_cells))
            base_mem[r_idx] <= ogmi_pkg::MARK_VALUE;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == ogmi_pkg::CMD_PT_MARK && r2_in_bound && ok_x && ok_y)
            mark_mem[mark_addr] <= 1'b1;
        else if (i_cmd == ogmi_pkg::CMD_CLR_STEP)
            mark_mem[AW'(r_clr)] <= 1'b0;
        here_m <= mark_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd == ogmi_pkg::CMD_FW_STEP) && r_ph == P_WR)
            dist_mem[r_idx] <= new_fw;
        else if ((i_cmd == ogmi_pkg::CMD_BW_STEP) && r_ph == P_WR)
            dist_mem[r_idx] <= new_bw;
        up_d   <= dist_mem[nb_idx];
        here_d <= dist_mem[r_idx];
    end

    // Quantizer pipeline registers (payload).
    always_ff @(posedge i_clk) begin
        if (i_cmd == ogmi_pkg::CMD_PT_MUL) begin
            r_neg_x    <= dx[32];
            r_neg_y    <= dy[32];
            r_mag_x    <= dx[32] ? 33'(-dx) : dx;
            r_mag_y    <= dy[32] ? 33'(-dy) : dy;
            r_in_bound <= (px < hx) && (px > -hx) && (py < hy) && (py > -hy);
        end
        r_prod_x    <= 66'(r_mag_x * {1'b0, i_inv_resolution});
        r_prod_y    <= 66'(r_mag_y * {1'b0, i_inv_resolution});
        r2_neg_x    <= r_neg_x;
        r2_neg_y    <= r_neg_y;
        r2_in_bound <= r_in_bound;
    end

    // Control registers: pointers, sweep position, clear counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_ptr <= '0;
            r_read_ptr <= '0;
            r_rd_idx   <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_idx      <= '0;
            r_clr      <= '0;
            r_ph       <= P_RD;
            r_d_left   <= '0;
            o_rd_last  <= 1'b0;
        end else begin
            case (i_cmd)
                ogmi_pkg::CMD_LOAD:
                    r_load_ptr <= (ld_cur + CW'(1) >= size) ? '0 : ld_cur + CW'(1);
                ogmi_pkg::CMD_RD_ADDR: begin
                    r_rd_idx  <= rd_cur;
                    o_rd_last <= (rd_cur + CW'(1) == size);
                end
                ogmi_pkg::CMD_RD_TAKE:
                    r_read_ptr <= (r_rd_idx + CW'(1) >= size) ? '0 : r_rd_idx + CW'(1);
                ogmi_pkg::CMD_FW_START: begin
                    r_row <= '0; r_col <= '0; r_idx <= '0; r_ph <= P_RD;
                end
                ogmi_pkg::CMD_BW_START: begin
                    r_row <= h_eff - SW'(1);
                    r_col <= w_eff - SW'(1);
                    r_idx <= AW'(size - CW'(1));
                    r_ph  <= P_RD;
                end
                ogmi_pkg::CMD_FW_STEP, ogmi_pkg::CMD_BW_STEP: begin
                    case (r_ph)
                        P_RD:   r_ph <= P_WAIT;
                        P_WAIT: r_ph <= P_WR;
                        default: begin
                            r_ph <= P_RD;
                            if (i_cmd == ogmi_pkg::CMD_FW_STEP) begin
                                r_d_left <= new_fw;
                                if (!fw_last) begin
                                    r_idx <= r_idx + AW'(1);
                                    if (r_col == w_eff - SW'(1)) begin
                                        r_col <= '0; r_row <= r_row + SW'(1);
                                    end else r_col <= r_col + SW'(1);
                                end
                            end else begin
                                r_d_left <= new_bw;
                                if (!bw_last) begin
                                    r_idx <= r_idx - AW'(1);
                                    if (r_col == '0) begin
                                        r_col <= w_eff - SW'(1); r_row <= r_row - SW'(1);
                                    end else r_col <= r_col - SW'(1);
                                end
                            end
                        end
                    endcase
                end
                ogmi_pkg::CMD_CLR_STEP:
                    r_clr <= (r_clr == CW'(CELLS - 1)) ? '0 : r_clr + CW'(1);
                default: ;
            endcase
        end
    end
endmodule

[hw/rtl/occupancy_grid_mark_and_inflate_unit.sv]
// Top level of the occupancy grid mark-and-inflate unit.
// Depends on ogmi_pkg, ogmi_ctrl and ogmi_datapath.
//
// Usage: items arrive on i_valid/o_ready with i_operation selecting load,
// point, inflate or read. Each accepted item is one transfer. Read items
// produce one transfer on o_valid/i_ready carrying o_cell_out and
// o_last_cell; the other operations produce none.
// Sequence: a load is written while the unit stays idle; a point registers
// a 33x33 multiply per axis, then writes the mark; a read goes through the
// registered base-grid memory port, then waits for its output slot. An
// inflate starts a forward and then a backward sweep, each stepping every
// grid cell through read, wait and write phases, then clears the whole
// MAX_SIDE*MAX_SIDE mark grid.
// Reset: control state, pointers and registers return to defaults; the mark
// grid starts cleared by a clearing pass over its MAX_SIDE*MAX_SIDE cells
// during which no item is accepted. The base grid is undefined until loaded.
// Stall: a read result holds on the output register until taken; the unit
// accepts no new item while a read waits for its output slot. The user must
// write configuration on the APB port only while the unit is idle, unenforced.
module occupancy_grid_mark_and_inflate_unit #(
    parameter int MAX_SIDE = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic signed [7:0]  i_cell_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [7:0] o_cell_out,
    output logic        o_last_cell,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [2:0] R_W = 3'd0, R_H = 3'd1, R_OX = 3'd2, R_OY = 3'd3,
                           R_IR = 3'd4, R_HX = 3'd5, R_HY = 3'd6, R_RAD = 3'd7;

    logic [7:0]  r_gw, r_gh, r_rad;
    logic [31:0] r_ox, r_oy, r_ir;
    logic [30:0] r_hx, r_hy;
    logic [2:0]  reg_idx;
    assign reg_idx = paddr[4:2];
    assign pready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= 8'd128; r_gh <= 8'd128;
            r_ox <= 32'hFFFCCCCD; r_oy <= 32'hFFFCCCCD;
            r_ir <= 32'd1310720;
            r_hx <= 31'd209715; r_hy <= 31'd209715;
            r_rad <= 8'd4;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                R_W:   r_gw <= pwdata[7:0];
                R_H:   r_gh <= pwdata[7:0];
                R_OX:  r_ox <= pwdata;
                R_OY:  r_oy <= pwdata;
                R_IR:  r_ir <= pwdata;
                R_HX:  r_hx <= pwdata[30:0];
                R_HY:  r_hy <= pwdata[30:0];
                R_RAD: r_rad <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx)
            R_W:   prdata = {24'd0, r_gw};
            R_H:   prdata = {24'd0, r_gh};
            R_OX:  prdata = r_ox;
            R_OY:  prdata = r_oy;
            R_IR:  prdata = r_ir;
            R_HX:  prdata = {1'b0, r_hx};
            R_HY:  prdata = {1'b0, r_hy};
            R_RAD: prdata = {24'd0, r_rad};
            default: prdata = '0;
        endcase
    end

    // Initial mark clearing after reset runs as a clear sweep.
    logic r_init;
    ogmi_pkg::t_cmd    cmd_c, cmd;
    ogmi_pkg::t_status status;
    logic ready_c;
    logic [7:0] rd_data;
    logic rd_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_init <= 1'b1;
        else if (r_init && status.clr_done) r_init <= 1'b0;
    end

    assign cmd     = r_init ? ogmi_pkg::CMD_CLR_STEP : cmd_c;
    assign o_ready = ready_c && !r_init;

    ogmi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid && !r_init),
        .i_operation (i_operation),
        .i_out_free  (!o_valid || i_ready),
        .i_status    (status),
        .o_ready     (ready_c),
        .o_cmd       (cmd_c)
    );

    ogmi_datapath #(.MAX_SIDE(MAX_SIDE)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cell_value     (i_cell_value),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_grid_width     (r_gw),
        .i_grid_height    (r_gh),
        .i_origin_x       (r_ox),
        .i_origin_y       (r_oy),
        .i_inv_resolution (r_ir),
        .i_half_extent_x  (r_hx),
        .i_half_extent_y  (r_hy),
        .i_radius_cells   (r_rad),
        .o_status         (status),
        .o_rd_data        (rd_data),
        .o_rd_last        (rd_last)
    );

    // Output register for read results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (cmd == ogmi_pkg::CMD_RD_TAKE) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (cmd == ogmi_pkg::CMD_RD_TAKE) begin
            o_cell_out  <= rd_data;
            o_last_cell <= rd_last;
        end
    end
endmodule

[test/tb_occupancy_grid_mark_and_inflate_unit.sv]
// Testbench for the occupancy grid mark-and-inflate unit.
// Drives load, point, inflate and read items against an internal grid model
// and checks every read transfer; depends on ogmi_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_occupancy_grid_mark_and_inflate_unit;
    localparam int SIDE = 128;
    localparam int CELLS = SIDE * SIDE;
    localparam int STALL_LIMIT = 200000;
    localparam int FAR = 32'hFFFF;

    localparam int REG_WIDTH = 0;
    localparam int REG_HEIGHT = 1;
    localparam int REG_ORIGIN_X = 2;
    localparam int REG_ORIGIN_Y = 3;
    localparam int REG_INV_RES = 4;
    localparam int REG_HALF_X = 5;
    localparam int REG_HALF_Y = 6;
    localparam int REG_RADIUS = 7;

    typedef struct {
        logic [1:0] op;
        logic signed [7:0] value;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } t_item;

    typedef struct {
        logic signed [7:0] cell_val;
        logic last;
    } t_cell_result;

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, o_valid, i_ready;
    logic [1:0] i_operation;
    logic signed [7:0] i_cell_value, o_cell_out;
    logic signed [31:0] i_point_x, i_point_y;
    logic o_last_cell;
    logic psel, penable, pwrite, pready;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;

    occupancy_grid_mark_and_inflate_unit dut (.*);

    // Grid model state and register shadows.
    logic [7:0] grid_w, grid_h, radius;
    logic signed [31:0] org_x, org_y;
    logic [31:0] inv_res;
    logic [30:0] half_x, half_y;
    logic signed [7:0] base_cells [CELLS];
    bit marks [CELLS];
    int dist_map [CELLS];
    int load_ptr, read_ptr;

    t_item pending_items[$];
    t_cell_result expected_cells[$];
    int errors, reads_checked, inflates_done, points_sent;
    bit in_fire, hold_req;

    function automatic int side_of(input logic [7:0] v);
        if (v == 0) return 1;
        if (v > SIDE) return SIDE;
        return v;
    endfunction

    // Round-to-nearest cell index on the exact Q32.32 product.
    function automatic bit cell_of(input longint p, input longint org, input int lim,
                                   output int idx);
        longint diff;
        logic [63:0] mag, prod, q;
        diff = p - org;
        mag = (diff < 0) ? -diff : diff;
        prod = mag * {32'd0, inv_res};
        if (diff < 0) begin
            if (prod > 64'h8000_0000) return 0;
            q = 0;
        end else begin
            q = (prod + 64'h8000_0000) >> 32;
        end
        if (q >= lim) return 0;
        idx = int'(q);
        return 1;
    endfunction

    // Two-pass Manhattan distance transform, then mark-value write and clear.
    task automatic inflate_grid(input int w, input int h);
        int i, d;
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++) begin
                i = r * w + c;
                d = marks[i] ? 0 : FAR;
                if (r > 0 && dist_map[i - w] + 1 < d) d = dist_map[i - w] + 1;
                if (c > 0 && dist_map[i - 1] + 1 < d) d = dist_map[i - 1] + 1;
                if (d > FAR) d = FAR;
                dist_map[i] = d;
            end
        for (int r = h - 1; r >= 0; r--)
            for (int c = w - 1; c >= 0; c--) begin
                i = r * w + c;
                d = dist_map[i];
                if (r + 1 < h && dist_map[i + w] + 1 < d) d = dist_map[i + w] + 1;
                if (c + 1 < w && dist_map[i + 1] + 1 < d) d = dist_map[i + 1] + 1;
                dist_map[i] = d;
                if (d <= radius) base_cells[i] = ogmi_pkg::MARK_VALUE;
            end
        for (int k = 0; k < CELLS; k++) marks[k] = 0;
    endtask

    task automatic apply_item(input t_item it);
        int w, h, sz, col, row;
        t_cell_result res;
        longint x, y;
        w = side_of(grid_w);
        h = side_of(grid_h);
        sz = w * h;
        x = it.px;
        y = it.py;
        case (it.op)
            ogmi_pkg::OP_LOAD: begin
                if (load_ptr >= sz) load_ptr = 0;
                base_cells[load_ptr] = it.value;
                load_ptr = (load_ptr + 1 >= sz) ? 0 : load_ptr + 1;
            end
            ogmi_pkg::OP_POINT: begin
                if (x < longint'(half_x) && x > -longint'(half_x) &&
                    y < longint'(half_y) && y > -longint'(half_y) &&
                    cell_of(x, org_x, w, col) && cell_of(y, org_y, h, row))
                    marks[row * w + col] = 1;
            end
            ogmi_pkg::OP_INFLATE: begin
                inflate_grid(w, h);
                inflates_done++;
            end
            default: begin
                if (read_ptr >= sz) read_ptr = 0;
                res.cell_val = base_cells[read_ptr];
                res.last = (read_ptr + 1 == sz);
                expected_cells.push_back(res);
                read_ptr = (read_ptr + 1 >= sz) ? 0 : read_ptr + 1;
            end
        endcase
    endtask

    // Clock; the single reset pulse is driven in the main initial block.
    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Input transfers feed the grid model; output transfers are checked.
    always @(posedge i_clk) begin
        t_item it;
        t_cell_result e;
        in_fire <= i_valid && o_ready;
        if (i_valid && o_ready) begin
            it.op = i_operation;
            it.value = i_cell_value;
            it.px = i_point_x;
            it.py = i_point_y;
            apply_item(it);
        end
        if (o_valid && i_ready) begin
            if (expected_cells.size() == 0) begin
                $error("read transfer with no cell expected");
                errors++;
            end else begin
                e = expected_cells.pop_front();
                reads_checked++;
                if (o_cell_out !== e.cell_val) begin
                    $error("cell_out: expected %0d, got %0d", e.cell_val, o_cell_out);
                    errors++;
                end
                if (o_last_cell !== e.last) begin
                    $error("last_cell: expected %0d, got %0d", e.last, o_last_cell);
                    errors++;
                end
            end
        end
    end

    // Sender: bursts of random length separated by random gaps.
    int burst_left, gap_left;
    always @(negedge i_clk) begin
        t_item it;
        bit offer;
        offer = i_valid && !in_fire;
        if (!offer && i_rst_n) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                i_operation <= it.op;
                i_cell_value <= it.value;
                i_point_x <= it.px;
                i_point_y <= it.py;
                offer = 1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        i_valid <= offer;
    end

    // Receiver: stall pattern that changes mode, plus one long hold-off.
    int rx_mode, rx_count, hold_left;
    bit hold_taken;
    always @(negedge i_clk) begin
        bit rdy;
        if (rx_count == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_count = $urandom_range(20, 120);
        end
        rx_count--;
        if (hold_req && !hold_taken) begin
            hold_taken = 1;
            hold_left = 500;
        end
        case (rx_mode)
            0: rdy = 1;
            1: rdy = $urandom_range(0, 1);
            default: rdy = ($urandom_range(0, 3) == 0);
        endcase
        if (hold_left > 0) begin
            hold_left--;
            rdy = 0;
        end
        i_ready <= rdy;
    end

    // Watchdog on cycles without any transfer.
    int idle_cycles;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic reg_write(input int index, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 5'(4 * index);
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (index)
            REG_WIDTH: grid_w = value[7:0];
            REG_HEIGHT: grid_h = value[7:0];
            REG_ORIGIN_X: org_x = value;
            REG_ORIGIN_Y: org_y = value;
            REG_INV_RES: inv_res = value;
            REG_HALF_X: half_x = value[30:0];
            REG_HALF_Y: half_y = value[30:0];
            default: radius = value[7:0];
        endcase
    endtask

    task automatic push_op(input logic [1:0] op, input logic signed [7:0] v,
                           input logic signed [31:0] x, input logic signed [31:0] y);
        t_item it;
        it.op = op;
        it.value = v;
        it.px = x;
        it.py = y;
        pending_items.push_back(it);
        if (op == ogmi_pkg::OP_POINT) points_sent++;
    endtask

    function automatic logic signed [7:0] rand_cell();
        return ($urandom_range(0, 9) == 0) ? -8'sd1 : 8'($urandom_range(0, 100));
    endfunction

    // Point aimed near the grid: cell offset plus fraction, clamped to 32 bits.
    function automatic logic signed [31:0] aim(input logic signed [31:0] org, input int n);
        longint step, off, v;
        step = (64'd1 << 32) / inv_res;
        if (step == 0) step = 1;
        off = longint'($urandom_range(0, 1000)) * (n + 2) * step / 1000 - step;
        v = org + off;
        if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) v = -64'sh8000_0000;
        return 32'(v);
    endfunction

    // Blocks until the unit has drained; the idle wait covers a pending inflate.
    task automatic drain();
        int w, h;
        while (pending_items.size() > 0 || i_valid || expected_cells.size() > 0)
            @(posedge i_clk);
        w = side_of(grid_w);
        h = side_of(grid_h);
        repeat (6 * w * h + CELLS + 100) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [7:0] w, input logic [7:0] h,
                            input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] ir, input logic [31:0] hx,
                            input logic [31:0] hy, input logic [7:0] r);
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_ORIGIN_X, ox);
        reg_write(REG_ORIGIN_Y, oy);
        reg_write(REG_INV_RES, ir);
        reg_write(REG_HALF_X, hx);
        reg_write(REG_HALF_Y, hy);
        reg_write(REG_RADIUS, r);
    endtask

    initial begin
        int w, h, n, pick;
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        i_operation = ogmi_pkg::OP_LOAD;
        i_cell_value = 0;
        i_point_x = 0;
        i_point_y = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        hold_req = 0;
        grid_w = 128;
        grid_h = 128;
        org_x = -209715;
        org_y = -209715;
        inv_res = 1310720;
        half_x = 209715;
        half_y = 209715;
        radius = 4;
        load_ptr = 0;
        read_ptr = 0;
        for (int k = 0; k < CELLS; k++) begin
            marks[k] = 0;
            base_cells[k] = 0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        // Let the mark grid clearing pass run out before configuring.
        repeat (CELLS + 100) @(posedge i_clk);

        // Directed: 3x2 grid, one cell per meter, origin at zero.
        set_regs(3, 2, 0, 0, 32'h0001_0000, 32'h0002_8000, 32'h0002_0000, 1);
        push_op(ogmi_pkg::OP_LOAD, -8'sd1, 0, 0);
        push_op(ogmi_pkg::OP_LOAD, 8'sd0, 0, 0);
        push_op(ogmi_pkg::OP_LOAD, 8'sd100, 0, 0);
        push_op(ogmi_pkg::OP_LOAD, 8'sd37, 0, 0);
        push_op(ogmi_pkg::OP_LOAD, 8'sd1, 0, 0);
        push_op(ogmi_pkg::OP_LOAD, 8'sd99, 0, 0);
        // On the strict y bound: ignored.
        push_op(ogmi_pkg::OP_POINT, 0, 0, 32'h0002_0000);
        // Exactly -0.5 cell: rounds to 0.
        push_op(ogmi_pkg::OP_POINT, 0, 32'hFFFF_8000, 0);
        // Just below: off grid.
        push_op(ogmi_pkg::OP_POINT, 0, 32'hFFFF_7FFF, 0);
        // Just inside the x bound: lands in the last column.
        push_op(ogmi_pkg::OP_POINT, 0, 32'h0002_7FFF, 32'h0001_0000);
        push_op(ogmi_pkg::OP_POINT, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        push_op(ogmi_pkg::OP_INFLATE, 0, 0, 0);
        for (int k = 0; k < 7; k++) push_op(ogmi_pkg::OP_READ, 0, 0, 0);
        drain();

        // Random phases over a spread of grid shapes and register extremes.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_regs(0, 0, 0, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
                1: set_regs(255, 1, 32'h8000_0000, 0, 32'h0001_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 3);
                2: set_regs(1, 200, 0, 32'h8000_0000, 32'h0001_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 255);
                3: set_regs(7, 5, 32'hFFFF_0000, 32'hFFFE_0000, 32'h0002_0000,
                            32'h0003_0000, 32'h0002_0000, 1);
                4: set_regs(9, 9, 0, 0, 32'h0001_0000, 0, 32'h7FFF_FFFF, 2);
                5: set_regs(128, 2, 32'h7FFF_FFFF, 0, 32'h0000_4000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 5);
                6: set_regs(12, 10, -209715, -209715, 1310720, 209715, 209715, 4);
                7: set_regs(5, 3, 0, 0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
                8: set_regs(16, 8, 32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
                default: set_regs(4, 4, 32'h1234_5678, 32'h8765_4321, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 2);
            endcase
            w = side_of(grid_w);
            h = side_of(grid_h);
            // Fill the whole grid so no read or inflate sees an unloaded cell.
            for (int k = 0; k < w * h; k++) push_op(ogmi_pkg::OP_LOAD, rand_cell(), 0, 0);
            // Reads queued during the long hold-off fill the output and stall the input.
            if (ph == 3) begin
                hold_req = 1;
                for (int k = 0; k < 3; k++) push_op(ogmi_pkg::OP_READ, 0, 0, 0);
            end
            n = 10;
            for (int k = 0; k < n; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 25) push_op(ogmi_pkg::OP_LOAD, rand_cell(), 0, 0);
                else if (pick < 50)
                    push_op(ogmi_pkg::OP_POINT, 0, aim(org_x, w), aim(org_y, h));
                else if (pick < 57) push_op(ogmi_pkg::OP_POINT, 0, $urandom, $urandom);
                else if (pick < 59) push_op(ogmi_pkg::OP_INFLATE, 0, 0, 0);
                else push_op(ogmi_pkg::OP_READ, 0, 0, 0);
            end
            push_op(ogmi_pkg::OP_INFLATE, 0, 0, 0);
            for (int k = 0; k < w * h && k < 12; k++) push_op(ogmi_pkg::OP_READ, 0, 0, 0);
            drain();
        end

        $display("Checked %0d read transfers over 11 register settings, %0d points, %0d inflates.",
                 reads_checked, points_sent, inflates_done);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
